// File: rtl/core/checksummed_frame_receiver_defines.svh
// assertion macros for the checksummed frame receiver
// the including module must provide clk and arst_n
`ifndef CHECKSUMMED_FRAME_RECEIVER_DEFINES_SVH
`define CHECKSUMMED_FRAME_RECEIVER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define CFR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define CFR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/cfr_pkg.sv
// shared constants, types and tables of the checksummed frame receiver
// no dependencies
package cfr_pkg;

	localparam int FRAME_BYTES = 8;
	localparam int MAX_FRAME   = 16;
	localparam int OUT_BYTES   = 8;
	localparam int VIEW_BYTES  = (FRAME_BYTES < OUT_BYTES) ? FRAME_BYTES : OUT_BYTES;
	localparam int POS_W       = $clog2(FRAME_BYTES);

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);
	localparam logic [7:0] HEADER_BYTE    = 8'h80;
	localparam logic [7:0] RUN_MAX        = 8'hFF;
	localparam logic [7:0] LIMIT_RESET    = 8'd5;

	// event code per item
	typedef enum logic [1:0] {
		EV_NONE     = 2'd0,
		EV_ACCEPT   = 2'd1,
		EV_CSUM_ERR = 2'd2,
		EV_DEFAULTS = 2'd3
	} event_t;

	typedef logic [7:0] byte_t;

	// neutral frame, bytes past eight default to zero
	localparam byte_t NEUTRAL_FRAME [MAX_FRAME] = '{
		8'h80, 8'h00, 8'h00, 8'h40, 8'h40, 8'h40, 8'h40, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	// one byte handed to the deframer
	typedef struct packed {
		logic  fire;
		byte_t rx_byte;
	} step_t;

	// one result item
	typedef struct packed {
		byte_t [OUT_BYTES-1:0] frame_byte;
		event_t                event_res;
	} result_t;

endpackage

// File: rtl/core/cfr_byte_if.sv
// received byte channel of the checksummed frame receiver
// depends on nothing
interface cfr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// File: rtl/core/cfr_result_if.sv
// result channel of the checksummed frame receiver: held frame and event code
// depends on nothing
interface cfr_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte_0;
	logic [7:0] frame_byte_1;
	logic [7:0] frame_byte_2;
	logic [7:0] frame_byte_3;
	logic [7:0] frame_byte_4;
	logic [7:0] frame_byte_5;
	logic [7:0] frame_byte_6;
	logic [7:0] frame_byte_7;
	logic [1:0] event_res;

	modport source (
		output valid, input ready,
		output frame_byte_0, output frame_byte_1, output frame_byte_2, output frame_byte_3,
		output frame_byte_4, output frame_byte_5, output frame_byte_6, output frame_byte_7,
		output event_res
	);
	modport sink (
		input valid, output ready,
		input frame_byte_0, input frame_byte_1, input frame_byte_2, input frame_byte_3,
		input frame_byte_4, input frame_byte_5, input frame_byte_6, input frame_byte_7,
		input event_res
	);
endinterface

// File: rtl/core/cfr_frame_core.sv
// deframer state: position, running sum, pending and held frames, error run
// depends on cfr_pkg
module cfr_frame_core (
	input  logic              clk,
	input  logic              arst_n,
	input  cfr_pkg::step_t    step,
	input  logic [7:0]        error_limit,
	output cfr_pkg::result_t  result
);

	logic [cfr_pkg::POS_W-1:0] pos_q, pos_c, pos_n;
	logic [6:0]                sum_q, sum_c, sum_n;
	logic [7:0]                run_q, run_n;
	cfr_pkg::byte_t            pending_q [cfr_pkg::FRAME_BYTES];
	cfr_pkg::byte_t            pending_n [cfr_pkg::FRAME_BYTES];
	cfr_pkg::byte_t            held_q    [cfr_pkg::FRAME_BYTES];
	cfr_pkg::byte_t            held_n    [cfr_pkg::FRAME_BYTES];
	cfr_pkg::event_t           event_c;
	logic                      header;

	// next state for one byte
	always_comb begin
		header    = (step.rx_byte == cfr_pkg::HEADER_BYTE);
		pos_c     = header ? '0 : pos_q;
		sum_c     = header ? '0 : sum_q;
		pending_n = pending_q;
		held_n    = held_q;
		run_n     = run_q;
		sum_n     = sum_c;
		pos_n     = pos_c;
		event_c   = cfr_pkg::EV_NONE;
		pending_n[pos_c] = step.rx_byte;
		if (pos_c == cfr_pkg::LAST_POS) begin
			if ({1'b0, sum_c} == step.rx_byte) begin
				// checksum match, position stays on the last byte
				run_n   = '0;
				held_n  = pending_n;
				event_c = cfr_pkg::EV_ACCEPT;
			end else begin
				// mismatch, saturating run count, restart position
				if (run_q != cfr_pkg::RUN_MAX) begin
					run_n = run_q + 8'd1;
				end
				event_c = cfr_pkg::EV_CSUM_ERR;
				if (run_n >= error_limit) begin
					for (int i = 0; i < cfr_pkg::FRAME_BYTES; i++) begin
						held_n[i] = cfr_pkg::NEUTRAL_FRAME[i];
					end
					event_c = cfr_pkg::EV_DEFAULTS;
				end
				pos_n = '0;
			end
		end else begin
			sum_n = sum_c + step.rx_byte[6:0];
			pos_n = pos_c + 1'b1;
		end
	end

	// result view of the updated held frame
	always_comb begin
		result.frame_byte = '0;
		for (int i = 0; i < cfr_pkg::VIEW_BYTES; i++) begin
			result.frame_byte[i] = held_n[i];
		end
		result.event_res = event_c;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
			run_q <= '0;
			for (int i = 0; i < cfr_pkg::FRAME_BYTES; i++) begin
				pending_q[i] <= cfr_pkg::NEUTRAL_FRAME[i];
				held_q[i]    <= cfr_pkg::NEUTRAL_FRAME[i];
			end
		end else if (step.fire) begin
			pos_q     <= pos_n;
			sum_q     <= sum_n;
			run_q     <= run_n;
			pending_q <= pending_n;
			held_q    <= held_n;
		end
	end

endmodule

// File: rtl/core/checksummed_frame_receiver.sv
// top level of the checksummed frame receiver: input register, deframer, result register
// depends on cfr_pkg, cfr_byte_if, cfr_result_if, cfr_frame_core and the defines header
//
//  channel | dir | handshake          | payload
//  rx      | in  | valid / ready      | rx_byte
//  res     | out | valid / ready      | frame_byte_0 .. frame_byte_7, event_res
//  cfg     | in  | cfg_we, no ready   | cfg_wdata (error_limit)
//
// one item per cycle sustained while the result is not stalled; an accepted item passes
// the input register, then the deframer step into the result register
// arst_n clears all control state and loads the neutral frame and a limit of 5
// a stalled result holds the result register; the input register still takes an item
// and rx.ready drops only when both the input and result registers are full
`include "checksummed_frame_receiver_defines.svh"

module checksummed_frame_receiver (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_wdata,
	cfr_byte_if.sink            rx,
	cfr_result_if.source        res
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              out_valid_q;
	cfr_pkg::result_t  out_data_q;
	logic [7:0]        error_limit_q;
	logic              advance;
	logic              rx_fire;
	cfr_pkg::step_t    step;
	cfr_pkg::result_t  result;
	logic              defaults_out;
	logic              head_neutral;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_limit_q <= cfr_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			error_limit_q <= cfg_wdata;
		end
	end

	// handshake
	assign advance  = valid_s1 && (!out_valid_q || res.ready);
	assign rx.ready = !valid_s1 || advance;
	assign rx_fire  = rx.valid && rx.ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_fire) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// deframer step
	assign step.fire    = advance;
	assign step.rx_byte = byte_s1;

	cfr_frame_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.error_limit (error_limit_q),
		.result      (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= result;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.frame_byte_0 = out_data_q.frame_byte[0];
	assign res.frame_byte_1 = out_data_q.frame_byte[1];
	assign res.frame_byte_2 = out_data_q.frame_byte[2];
	assign res.frame_byte_3 = out_data_q.frame_byte[3];
	assign res.frame_byte_4 = out_data_q.frame_byte[4];
	assign res.frame_byte_5 = out_data_q.frame_byte[5];
	assign res.frame_byte_6 = out_data_q.frame_byte[6];
	assign res.frame_byte_7 = out_data_q.frame_byte[7];
	assign res.event_res    = out_data_q.event_res;

	// checks
	assign defaults_out = res.valid && (res.event_res == cfr_pkg::EV_DEFAULTS);
	assign head_neutral = (res.frame_byte_0 == cfr_pkg::NEUTRAL_FRAME[0]);

	`CFR_ASSERT_NEXT(a_accept_fills_s1, rx_fire, valid_s1, "item lost before input register")
	`CFR_ASSERT_NEXT(a_step_gives_result, advance, res.valid, "deframer step gave no result")
	`CFR_ASSERT_NOW(a_defaults_header, defaults_out, head_neutral, "defaults without neutral frame")

endmodule
